### hdl/sbus_frame_decoder_core_assert.svh
// Assertion macros for the SBUS frame decoder core.
`ifndef SBUS_FRAME_DECODER_CORE_ASSERT_SVH
`define SBUS_FRAME_DECODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, reset-qualified.
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, reset-qualified.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFD_ASSERT_IMP(label, ante, cons, msg)
`define SFD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hdl/sfd_pkg.sv
// Shared types and constants of the SBUS frame decoder.
`default_nettype none
package sfd_pkg;
	localparam int unsigned FRAME_LEN  = 25;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CH_W       = 11;
	localparam int unsigned NUM_CH     = 10;
	localparam int unsigned CH_BYTES   = 14;
	localparam int unsigned STATUS_POS = 23;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned IDX_W      = 3;
	localparam int unsigned CFG_W      = 11;
	localparam int unsigned OUT_W      = 80;

	localparam logic [BYTE_W-1:0] HEAD_VAL = 8'h0F;
	localparam logic [BYTE_W-1:0] END_VAL  = 8'h00;

	localparam logic [CH_W-1:0]   RST_CENTER_OFFSET  = 11'd1024;
	localparam logic [CH_W-1:0]   RST_DEAD_ZONE      = 11'd120;
	localparam logic [CH_W-1:0]   RST_TWO_POS        = 11'd1024;
	localparam logic [CH_W-1:0]   RST_THREE_POS_LOW  = 11'd600;
	localparam logic [CH_W-1:0]   RST_THREE_POS_HIGH = 11'd1400;
	localparam logic [BYTE_W-1:0] RST_OFFLINE_STATUS = 8'd12;

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_OFFSET  = 3'd0,
		REG_DEAD_ZONE      = 3'd1,
		REG_TWO_POS        = 3'd2,
		REG_THREE_POS_LOW  = 3'd3,
		REG_THREE_POS_HIGH = 3'd4,
		REG_OFFLINE_STATUS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0]   center_offset;
		logic [CH_W-1:0]   dead_zone;
		logic [CH_W-1:0]   two_pos_threshold;
		logic [CH_W-1:0]   three_pos_low;
		logic [CH_W-1:0]   three_pos_high;
		logic [BYTE_W-1:0] offline_status;
	} cfg_t;
endpackage
`default_nettype wire

### hdl/sbus_frame_decoder_core.sv
// SBUS frame decoder: byte chain, frame check, channel decode and output register.
// Throughput: one byte per cycle; s_tready drops only while a decoded frame is
// held in the decode stage and the output register is stalled.
// A good frame is captured into the decode stage on its last byte, then moves
// into the output register, whose valid bit presents the result.
// Reset (arst_n low, asynchronous): byte count, overflow flag and valid bits clear,
// configuration returns to defaults; the byte chain is not reset.
`default_nettype none
`include "sbus_frame_decoder_core_assert.svh"
module sbus_frame_decoder_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
	input  wire logic                        s_tlast,   // frame_last
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// [0] online, [11:1] stick_lx, [22:12] stick_ly, [33:23] stick_rx,
	// [44:34] stick_ry, [45] switch_a, [47:46] switch_b, [49:48] switch_c,
	// [50] switch_d, [61:51] aux_a, [72:62] aux_b, [79:73] zero
	output logic [sfd_pkg::OUT_W-1:0]        m_tdata,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [sfd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [sfd_pkg::CFG_W-1:0]   cfg_data
);
	localparam logic [sfd_pkg::CNT_W-1:0] FULL_CNT = sfd_pkg::CNT_W'(sfd_pkg::FRAME_LEN);
	localparam logic [sfd_pkg::CNT_W-1:0] LAST_CNT = sfd_pkg::CNT_W'(sfd_pkg::FRAME_LEN - 1);

	sfd_pkg::cfg_t cfg_q;

	logic [sfd_pkg::CNT_W-1:0]  count_q;
	logic                       ovf_q;
	logic [sfd_pkg::BYTE_W-1:0] chain [sfd_pkg::FRAME_LEN];

	logic in_acc;
	logic shift_en;
	logic frame_take;

	logic                                         valid_s1;
	logic [sfd_pkg::CH_BYTES*sfd_pkg::BYTE_W-1:0] chan_bytes_s1;
	logic [sfd_pkg::BYTE_W-1:0]                   status_s1;
	logic                                         advance_s1;

	logic                        m_valid_q;
	logic [sfd_pkg::OUT_W-1:0]   m_data_q;

	logic [sfd_pkg::CH_W-1:0]          ch [sfd_pkg::NUM_CH];
	logic signed [sfd_pkg::CH_W-1:0]   stick_lx, stick_ly, stick_rx, stick_ry;
	logic                              online, switch_a, switch_d;
	logic [1:0]                        switch_b, switch_c;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_offset     <= sfd_pkg::RST_CENTER_OFFSET;
			cfg_q.dead_zone         <= sfd_pkg::RST_DEAD_ZONE;
			cfg_q.two_pos_threshold <= sfd_pkg::RST_TWO_POS;
			cfg_q.three_pos_low     <= sfd_pkg::RST_THREE_POS_LOW;
			cfg_q.three_pos_high    <= sfd_pkg::RST_THREE_POS_HIGH;
			cfg_q.offline_status    <= sfd_pkg::RST_OFFLINE_STATUS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfd_pkg::REG_CENTER_OFFSET:  cfg_q.center_offset     <= cfg_data;
				sfd_pkg::REG_DEAD_ZONE:      cfg_q.dead_zone         <= cfg_data;
				sfd_pkg::REG_TWO_POS:        cfg_q.two_pos_threshold <= cfg_data;
				sfd_pkg::REG_THREE_POS_LOW:  cfg_q.three_pos_low     <= cfg_data;
				sfd_pkg::REG_THREE_POS_HIGH: cfg_q.three_pos_high    <= cfg_data;
				sfd_pkg::REG_OFFLINE_STATUS:
					cfg_q.offline_status <= cfg_data[sfd_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// input side
	assign advance_s1 = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;
	assign in_acc     = s_tvalid && s_tready;
	assign shift_en   = in_acc && (count_q < FULL_CNT);

	// incoming byte is the 25th: byte 0 sits in chain[23], byte 24 is on the bus
	assign frame_take = in_acc && s_tlast && (count_q == LAST_CNT) && !ovf_q &&
		(chain[sfd_pkg::FRAME_LEN-2] == sfd_pkg::HEAD_VAL) &&
		(s_tdata == sfd_pkg::END_VAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_acc) begin
			if (s_tlast) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (count_q < FULL_CNT) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// byte chain: newest byte in cell 0
	for (genvar g = 0; g < sfd_pkg::FRAME_LEN; g++) begin : g_chain
		if (g == 0) begin : g_head
			sfd_byte_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d        (s_tdata),
				.q        (chain[g])
			);
		end else begin : g_body
			sfd_byte_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d        (chain[g-1]),
				.q        (chain[g])
			);
		end
	end

	// decode stage: capture channel bytes 1..14 and the status byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_take) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			for (int j = 0; j < sfd_pkg::CH_BYTES; j++) begin
				chan_bytes_s1[j*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] <=
					chain[sfd_pkg::FRAME_LEN-3-j];
			end
			status_s1 <= chain[sfd_pkg::FRAME_LEN-2-sfd_pkg::STATUS_POS];
		end
	end

	// channels are packed LSB first from byte 1
	always_comb begin
		for (int k = 0; k < sfd_pkg::NUM_CH; k++) begin
			ch[k] = chan_bytes_s1[k*sfd_pkg::CH_W +: sfd_pkg::CH_W];
		end
	end

	sfd_stick u_stick_lx (.ch(ch[3]), .cfg(cfg_q), .use_dead(1'b1), .val(stick_lx));
	sfd_stick u_stick_ly (.ch(ch[2]), .cfg(cfg_q), .use_dead(1'b0), .val(stick_ly));
	sfd_stick u_stick_rx (.ch(ch[0]), .cfg(cfg_q), .use_dead(1'b1), .val(stick_rx));
	sfd_stick u_stick_ry (.ch(ch[1]), .cfg(cfg_q), .use_dead(1'b1), .val(stick_ry));

	always_comb begin
		online   = (status_s1 != cfg_q.offline_status);
		switch_a = (ch[4] >= cfg_q.two_pos_threshold);
		switch_d = (ch[7] >= cfg_q.two_pos_threshold);
		if (ch[5] < cfg_q.three_pos_low) begin
			switch_b = 2'd0;
		end else if (ch[5] <= cfg_q.three_pos_high) begin
			switch_b = 2'd1;
		end else begin
			switch_b = 2'd2;
		end
		if (ch[6] < cfg_q.three_pos_low) begin
			switch_c = 2'd0;
		end else if (ch[6] <= cfg_q.three_pos_high) begin
			switch_c = 2'd1;
		end else begin
			switch_c = 2'd2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			m_data_q <= {7'b0, ch[9], ch[8], switch_d, switch_c, switch_b, switch_a,
				stick_ry, stick_rx, stick_ly, stick_lx, online};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`SFD_ASSERT_IMP(a_count_range, 1'b1, count_q <= FULL_CNT, "byte count beyond frame length")
	`SFD_ASSERT_IMP(a_ovf_full, ovf_q, count_q == FULL_CNT, "overflow set before frame filled")
	`SFD_ASSERT_IMP(a_take_room, frame_take, !valid_s1 || advance_s1, "frame over held frame")
	`SFD_ASSERT_NEXT(a_last_clears, in_acc && s_tlast, count_q == '0 && !ovf_q, "stale count")
endmodule
`default_nettype wire

### hdl/sfd_byte_cell.sv
// One byte cell of the frame shift chain.
`default_nettype none
module sfd_byte_cell (
	input  wire logic                       clk,
	input  wire logic                       shift_en,
	input  wire logic [sfd_pkg::BYTE_W-1:0] d,
	output logic      [sfd_pkg::BYTE_W-1:0] q
);
	logic [sfd_pkg::BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;
endmodule
`default_nettype wire

### hdl/sfd_stick.sv
// Stick channel centering, dead zone and saturation.
`default_nettype none
module sfd_stick (
	input  wire logic [sfd_pkg::CH_W-1:0] ch,
	input  wire sfd_pkg::cfg_t            cfg,
	input  wire logic                     use_dead,
	output logic signed [sfd_pkg::CH_W-1:0] val
);
	logic signed [sfd_pkg::CH_W+1:0] diff;
	logic signed [sfd_pkg::CH_W+1:0] dz;
	logic                            in_dz;

	always_comb begin
		diff  = $signed({2'b00, ch}) - $signed({2'b00, cfg.center_offset});
		dz    = $signed({2'b00, cfg.dead_zone});
		in_dz = use_dead && (diff > -dz) && (diff < dz);
		// compare at full precision, saturate afterwards
		if (in_dz) begin
			val = '0;
		end else if (diff > 13'sd1023) begin
			val = 11'sh3FF;
		end else if (diff < -13'sd1024) begin
			val = 11'sh400;
		end else begin
			val = diff[sfd_pkg::CH_W-1:0];
		end
	end
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the SBUS frame decoder core: frame stimulus, decode prediction.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sfd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int NUM_PHASES = 8;
	localparam int FRAMES_PER_PHASE = 4;
	localparam int NUM_ROWS = 10;

	// Result word as the core packs it, lowest field last.
	typedef struct packed {
		logic [6:0]  pad;
		logic [10:0] aux_b;
		logic [10:0] aux_a;
		logic        switch_d;
		logic [1:0]  switch_c;
		logic [1:0]  switch_b;
		logic        switch_a;
		logic [10:0] stick_ry;
		logic [10:0] stick_rx;
		logic [10:0] stick_ly;
		logic [10:0] stick_lx;
		logic        online;
	} sbus_result_t;

	typedef struct packed {
		logic [5:0]       len;
		logic [7:0]       head;
		logic [7:0]       tail;
		logic [7:0]       status;
		logic [7:0]       filler;
		logic [9:0][10:0] chans;
		logic             typed;
		logic             gives;
		sbus_result_t     res;
	} frame_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_reg_t    cfg_index;
	logic [10:0] cfg_data;

	// decoder shadow state
	logic [7:0]   frame_bytes [0:24];
	logic [4:0]   byte_total;
	bit           overrun;
	cfg_t         cfg_shadow;
	sbus_result_t expected_frames [$];

	logic [7:0]   frame_buf [0:39];
	frame_row_t   dir_rows [0:NUM_ROWS-1];
	bit           use_typed;
	bit           typed_gives;
	sbus_result_t typed_res;
	int           idle_pct;
	int           stall_pct;
	int           hold_asks;
	int           fail_count;
	int           quiet_cycles;

	sbus_frame_decoder_core dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [10:0] center_stick(logic [10:0] ch, bit dz_on);
		int v;
		int dz;
		v = int'(ch) - int'(cfg_shadow.center_offset);
		dz = int'(cfg_shadow.dead_zone);
		if (dz_on && v > -dz && v < dz)
			v = 0;
		if (v > 1023)
			v = 1023;
		if (v < -1024)
			v = -1024;
		return v[10:0];
	endfunction

	function automatic logic [1:0] three_way(logic [10:0] ch);
		if (ch < cfg_shadow.three_pos_low)
			return 2'd0;
		if (ch <= cfg_shadow.three_pos_high)
			return 2'd1;
		return 2'd2;
	endfunction

	function automatic sbus_result_t decode_frame();
		logic [111:0] bits;
		logic [10:0]  ch [0:9];
		sbus_result_t r;
		bits = '0;
		for (int k = 1; k <= 14; k++)
			bits[(k-1)*8 +: 8] = frame_bytes[k];
		for (int i = 0; i < 10; i++)
			ch[i] = bits[i*11 +: 11];
		r = '0;
		r.online = (frame_bytes[STATUS_POS] == cfg_shadow.offline_status) ? 1'b0 : 1'b1;
		r.stick_lx = center_stick(ch[3], 1'b1);
		r.stick_ly = center_stick(ch[2], 1'b0);
		r.stick_rx = center_stick(ch[0], 1'b1);
		r.stick_ry = center_stick(ch[1], 1'b1);
		r.switch_a = (ch[4] >= cfg_shadow.two_pos_threshold);
		r.switch_b = three_way(ch[5]);
		r.switch_c = three_way(ch[6]);
		r.switch_d = (ch[7] >= cfg_shadow.two_pos_threshold);
		r.aux_a = ch[8];
		r.aux_b = ch[9];
		return r;
	endfunction

	// Advance the shadow by one byte; returns 1 when a good frame closes.
	function automatic bit absorb_byte(logic [7:0] b, bit last, output sbus_result_t r);
		bit good;
		r = '0;
		if (byte_total < FRAME_LEN) begin
			frame_bytes[byte_total] = b;
			byte_total++;
		end else begin
			overrun = 1'b1;
		end
		if (!last)
			return 1'b0;
		good = byte_total == FRAME_LEN && !overrun && frame_bytes[0] == HEAD_VAL &&
			frame_bytes[FRAME_LEN-1] == END_VAL;
		byte_total = '0;
		overrun = 1'b0;
		if (good)
			r = decode_frame();
		return good;
	endfunction

	function automatic sbus_result_t result_of(int on, int lh, int lv, int rh, int rv,
			int sa, int sb, int sc, int sd, int aa, int ab);
		sbus_result_t r;
		r = '0;
		r.online = 1'(on);
		r.stick_lx = 11'(lh);
		r.stick_ly = 11'(lv);
		r.stick_rx = 11'(rh);
		r.stick_ry = 11'(rv);
		r.switch_a = 1'(sa);
		r.switch_b = 2'(sb);
		r.switch_c = 2'(sc);
		r.switch_d = 1'(sd);
		r.aux_a = 11'(aa);
		r.aux_b = 11'(ab);
		return r;
	endfunction

	// Bias channels toward the dead-zone and threshold edges of the current setting.
	function automatic logic [10:0] pick_channel();
		int c;
		int nudge;
		nudge = int'($urandom_range(2)) - 1;
		case ($urandom_range(5))
			0: c = int'(cfg_shadow.center_offset) + int'(cfg_shadow.dead_zone) + nudge;
			1: c = int'(cfg_shadow.center_offset) - int'(cfg_shadow.dead_zone) + nudge;
			2: c = int'(cfg_shadow.two_pos_threshold) + nudge;
			3: c = int'(cfg_shadow.three_pos_low) + nudge;
			4: c = int'(cfg_shadow.three_pos_high) + nudge;
			default: c = int'($urandom_range(2047));
		endcase
		if (c < 0 || c > 2047)
			c = int'($urandom_range(2047));
		return c[10:0];
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic compare_result(sbus_result_t e, sbus_result_t a);
		check_field("online", e.online, a.online);
		check_field("stick_lx", $signed(e.stick_lx), $signed(a.stick_lx));
		check_field("stick_ly", $signed(e.stick_ly), $signed(a.stick_ly));
		check_field("stick_rx", $signed(e.stick_rx), $signed(a.stick_rx));
		check_field("stick_ry", $signed(e.stick_ry), $signed(a.stick_ry));
		check_field("switch_a", e.switch_a, a.switch_a);
		check_field("switch_b", e.switch_b, a.switch_b);
		check_field("switch_c", e.switch_c, a.switch_c);
		check_field("switch_d", e.switch_d, a.switch_d);
		check_field("aux_a", e.aux_a, a.aux_a);
		check_field("aux_b", e.aux_b, a.aux_b);
		check_field("pad", e.pad, a.pad);
	endtask

	// Drive one byte request from a falling edge; return at the falling edge after it is taken.
	task automatic send_byte(logic [7:0] b, bit last);
		sbus_result_t r;
		bit gave;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		gave = absorb_byte(b, last, r);
		if (last && use_typed) begin
			if (typed_gives)
				expected_frames.push_back(typed_res);
		end else if (gave) begin
			expected_frames.push_back(r);
		end
		@(negedge clk);
	endtask

	// Hold the sender until every expected result is out, then let the pipe settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_frames.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic fill_frame(logic [7:0] head, logic [7:0] tail, logic [7:0] status,
			logic [7:0] filler, logic [9:0][10:0] chans, bit rand_fill);
		logic [111:0] bits;
		bits = {filler[1:0], chans};
		frame_buf[0] = head;
		for (int k = 1; k <= 14; k++)
			frame_buf[k] = bits[(k-1)*8 +: 8];
		for (int k = 15; k < 40; k++)
			frame_buf[k] = rand_fill ? 8'($urandom) : filler;
		frame_buf[STATUS_POS] = status;
		frame_buf[FRAME_LEN-1] = tail;
	endtask

	task automatic send_frame(int len, int pause_at);
		for (int k = 0; k < len; k++) begin
			send_byte(frame_buf[k], k == len - 1);
			if (k == pause_at)
				wait_idle();
		end
	endtask

	task automatic send_random_frame(int pause_at);
		logic [9:0][10:0] chans;
		logic [7:0]       head;
		logic [7:0]       tail;
		logic [7:0]       status;
		int               len;
		bit               garbage;
		for (int i = 0; i < 10; i++)
			chans[i] = ($urandom_range(2) == 0) ? pick_channel() : 11'($urandom);
		status = ($urandom_range(3) == 0) ? cfg_shadow.offline_status : 8'($urandom);
		head = HEAD_VAL;
		tail = END_VAL;
		len = FRAME_LEN;
		garbage = 1'b0;
		if ($urandom_range(99) >= 85) begin
			case ($urandom_range(4))
				0: len = $urandom_range(24, 1);
				1: len = $urandom_range(40, 26);
				2: begin
					head = 8'($urandom);
					if (head == HEAD_VAL)
						head = ~HEAD_VAL;
				end
				3: tail = 8'($urandom_range(255, 1));
				default: garbage = 1'b1;
			endcase
		end
		fill_frame(head, tail, status, 8'($urandom), chans, 1'b1);
		if (garbage) begin
			for (int k = 0; k < 40; k++)
				frame_buf[k] = 8'($urandom);
			len = $urandom_range(40, 1);
		end
		send_frame(len, pause_at);
	endtask

	// Write all six registers back to back; valid stays high across the burst.
	task automatic apply_config(cfg_t c);
		cfg_reg_t    regs [0:5];
		logic [10:0] vals [0:5];
		regs = '{REG_CENTER_OFFSET, REG_DEAD_ZONE, REG_TWO_POS, REG_THREE_POS_LOW,
			REG_THREE_POS_HIGH, REG_OFFLINE_STATUS};
		vals = '{c.center_offset, c.dead_zone, c.two_pos_threshold, c.three_pos_low,
			c.three_pos_high, {3'b000, c.offline_status}};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			forever begin
				@(posedge clk);
				if (cfg_ready)
					break;
			end
			case (regs[i])
				REG_CENTER_OFFSET: cfg_shadow.center_offset = vals[i];
				REG_DEAD_ZONE: cfg_shadow.dead_zone = vals[i];
				REG_TWO_POS: cfg_shadow.two_pos_threshold = vals[i];
				REG_THREE_POS_LOW: cfg_shadow.three_pos_low = vals[i];
				REG_THREE_POS_HIGH: cfg_shadow.three_pos_high = vals[i];
				REG_OFFLINE_STATUS: cfg_shadow.offline_status = vals[i][7:0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		sbus_result_t act;
		if (arst_n && m_tvalid && m_tready) begin
			act = m_tdata;
			if (expected_frames.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				compare_result(expected_frames.pop_front(), act);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no request moved for %0d cycles", $time, quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		cfg_t phase_cfg;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CENTER_OFFSET;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_asks = 0;
		fail_count = 0;
		quiet_cycles = 0;
		use_typed = 1'b0;
		typed_gives = 1'b0;
		typed_res = '0;
		byte_total = '0;
		overrun = 1'b0;
		for (int k = 0; k < FRAME_LEN; k++)
			frame_bytes[k] = '0;
		cfg_shadow = '{RST_CENTER_OFFSET, RST_DEAD_ZONE, RST_TWO_POS, RST_THREE_POS_LOW,
			RST_THREE_POS_HIGH, RST_OFFLINE_STATUS};

		// len, head, tail, status, filler, channels 9..0, typed, gives, result
		dir_rows = '{
			'{6'd25, HEAD_VAL, END_VAL, 8'h00, 8'h00, {10{11'd0}}, 1'b1, 1'b1,
				result_of(1, -1024, -1024, -1024, -1024, 0, 0, 0, 0, 0, 0)},
			'{6'd25, HEAD_VAL, END_VAL, 8'h0C, 8'hFF, {10{11'd2047}}, 1'b1, 1'b1,
				result_of(0, 1023, 1023, 1023, 1023, 1, 2, 2, 1, 2047, 2047)},
			'{6'd25, HEAD_VAL, END_VAL, 8'h55, 8'hA5, {10{11'd1024}}, 1'b1, 1'b1,
				result_of(1, 0, 0, 0, 0, 1, 1, 1, 1, 1024, 1024)},
			// dead-zone and threshold edges at the reset setting
			'{6'd25, HEAD_VAL, END_VAL, 8'h0C, 8'h3C,
				{11'd1, 11'd2047, 11'd1024, 11'd1401, 11'd599, 11'd1023, 11'd1144,
				11'd1100, 11'd904, 11'd1143}, 1'b0, 1'b0, sbus_result_t'('0)},
			// short frame
			'{6'd24, HEAD_VAL, END_VAL, 8'h00, 8'h00, {10{11'd1024}}, 1'b1, 1'b0,
				sbus_result_t'('0)},
			// long frame
			'{6'd26, HEAD_VAL, END_VAL, 8'h00, 8'h00, {10{11'd1024}}, 1'b1, 1'b0,
				sbus_result_t'('0)},
			// bad head byte
			'{6'd25, 8'h8F, END_VAL, 8'h00, 8'h00, {10{11'd1024}}, 1'b1, 1'b0,
				sbus_result_t'('0)},
			// bad end byte
			'{6'd25, HEAD_VAL, 8'h01, 8'h00, 8'h00, {10{11'd1024}}, 1'b1, 1'b0,
				sbus_result_t'('0)},
			// frame of a single byte
			'{6'd1, HEAD_VAL, END_VAL, 8'h00, 8'h00, {10{11'd1024}}, 1'b1, 1'b0,
				sbus_result_t'('0)},
			'{6'd25, HEAD_VAL, END_VAL, 8'hF0, 8'h5A,
				{11'h5A3, 11'h2C6, 11'h7E1, 11'h013, 11'h3FF, 11'h400, 11'h19B,
				11'h6D2, 11'h0A5, 11'h555}, 1'b0, 1'b0, sbus_result_t'('0)}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// long output hold-off while bytes keep coming; the first rows are good
		// frames, so the input backs up
		hold_asks++;
		for (int r = 0; r < NUM_ROWS; r++) begin
			fill_frame(dir_rows[r].head, dir_rows[r].tail, dir_rows[r].status,
				dir_rows[r].filler, dir_rows[r].chans, 1'b0);
			use_typed = dir_rows[r].typed;
			typed_gives = dir_rows[r].gives;
			typed_res = dir_rows[r].res;
			send_frame(dir_rows[r].len, -1);
		end
		use_typed = 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: phase_cfg = '{RST_CENTER_OFFSET, RST_DEAD_ZONE, RST_TWO_POS,
					RST_THREE_POS_LOW, RST_THREE_POS_HIGH, RST_OFFLINE_STATUS};
				1: phase_cfg = '{11'd0, 11'd0, 11'd0, 11'd0, 11'd2047, 8'd0};
				// crossed three-position thresholds in phases 2 and 3
				2: phase_cfg = '{11'd2047, 11'd1024, 11'd2047, 11'd2047, 11'd0, 8'd255};
				3: phase_cfg = '{11'd1024, 11'd1, 11'd1, 11'd1400, 11'd600, 8'd12};
				default: phase_cfg = '{11'($urandom), 11'($urandom_range(1024)),
					11'($urandom), 11'($urandom), 11'($urandom), 8'($urandom)};
			endcase
			apply_config(phase_cfg);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct = 32;
					stall_pct = 32;
				end
			endcase
			for (int f = 0; f < FRAMES_PER_PHASE; f++)
				send_random_frame((p == 1 && f == 2) ? 10 : -1);
		end

		wait_idle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### sbus_frame_decoder_core.f
+incdir+hdl
hdl/sfd_pkg.sv
hdl/sfd_byte_cell.sv
hdl/sfd_stick.sv
hdl/sbus_frame_decoder_core.sv
bench/testbench.sv
